// ===== design/png_scanline_unfilter_macros.svh =====
// Assertion macros used by the scanline unfilter top level.
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/psu_pkg.sv =====
// Shared types and constants of the PNG scanline unfilter.
`timescale 1ns / 1ps
package psu_pkg;

  localparam int unsigned DATA_W           = 8;
  localparam int unsigned BPP_W            = 4;
  localparam int unsigned LINE_BYTES_W     = 14;
  localparam int unsigned CFG_DATA_W       = 14;
  localparam int unsigned MAX_LINE_BYTES_DEF  = 8192;
  localparam int unsigned MAX_PIXEL_BYTES_DEF = 8;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_BYTES_PER_PIXEL = 1'b0,
    CFG_LINE_BYTES      = 1'b1
  } cfg_idx_e;

  // Filter kinds; anything above Paeth is kept as the bad code
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4,
    FLT_BAD   = 3'd5
  } filter_e;

  // Per-byte control decided by the front end
  typedef struct packed {
    filter_e kind;
    logic    top;
    logic    has_left;
    logic    last;
  } item_ctl_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== design/psu_in_if.sv =====
// Input byte channel and output result channel of the scanline unfilter.
`timescale 1ns / 1ps
interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] recon_byte;
  logic       line_end;
  logic       filter_error;

  modport source (output valid, output recon_byte, output line_end, output filter_error,
                  input ready);
  modport sink (input valid, input recon_byte, input line_end, input filter_error,
                output ready);
endinterface

// ===== design/psu_fifo.sv =====
// Two-entry request queue between the front end and the reconstruction back end.
`timescale 1ns / 1ps
module psu_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     rdata_o,
  output psu_pkg::fifo_stat_t  stat_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign rdata_o      = entry_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/psu_front.sv =====
// Front end: tracks scanline position, takes filter bytes, queues data bytes.
`timescale 1ns / 1ps
module psu_front #(
  parameter int unsigned MAX_LINE_BYTES = psu_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  psu_in_if.sink                   in_ch,
  input  logic [psu_pkg::BPP_W-1:0] bpp_i,
  input  logic [((MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1):0] len_i,
  input  logic                     q_ready_i,
  output logic                     push_o,
  output psu_pkg::item_ctl_t       ctl_o,
  output logic [psu_pkg::DATA_W-1:0] x_o,
  output logic [((MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1)-1:0] col_o
);

  localparam int unsigned COL_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int unsigned LEN_W = COL_W + 1;

  psu_pkg::filter_e kind_q;
  logic             awaiting_q;
  logic             top_q;
  logic [COL_W-1:0] col_q;

  logic             accept;
  logic             await_eff;
  logic             top_eff;
  logic [COL_W-1:0] col_eff;
  logic [LEN_W-1:0] col_inc;
  logic             last;
  psu_pkg::filter_e kind_new;

  assign in_ch.ready = q_ready_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // a start byte restarts the image and is always a filter byte
  always_comb begin
    await_eff = awaiting_q || in_ch.image_start;
    top_eff   = top_q || in_ch.image_start;
    col_eff   = in_ch.image_start ? '0 : col_q;
    col_inc   = {1'b0, col_eff} + LEN_W'(1);
    last      = (col_inc >= len_i);
    kind_new  = (in_ch.data_byte > 8'd4) ? psu_pkg::FLT_BAD
                                         : psu_pkg::filter_e'(in_ch.data_byte[2:0]);
  end

  // queued request for the back end
  assign push_o         = accept && !await_eff;
  assign ctl_o.kind     = kind_q;
  assign ctl_o.top      = top_eff;
  assign ctl_o.has_left = (32'(col_eff) >= 32'(bpp_i));
  assign ctl_o.last     = last;
  assign x_o            = in_ch.data_byte;
  assign col_o          = col_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= psu_pkg::FLT_NONE;
      awaiting_q <= 1'b1;
      top_q      <= 1'b1;
      col_q      <= '0;
    end else if (accept) begin
      if (await_eff) begin
        kind_q     <= kind_new;
        awaiting_q <= 1'b0;
        top_q      <= top_eff;
        col_q      <= '0;
      end else begin
        awaiting_q <= last;
        top_q      <= top_eff && !last;
        col_q      <= last ? '0 : col_inc[COL_W-1:0];
      end
    end
  end

endmodule

// ===== design/psu_back.sv =====
// Back end: line store read, byte reconstruction and the output register.
`timescale 1ns / 1ps
module psu_back #(
  parameter int unsigned MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES_DEF,
  parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [psu_pkg::BPP_W-1:0]  bpp_i,
  input  logic                       q_valid_i,
  input  psu_pkg::item_ctl_t         q_ctl_i,
  input  logic [psu_pkg::DATA_W-1:0] q_x_i,
  input  logic [((MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1)-1:0] q_col_i,
  output logic                       pop_o,
  psu_out_if.source                  out_ch
);

  localparam int unsigned COL_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int unsigned PIX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // full-precision Paeth predictor, ties go left, up, upper-left
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] dpa, dpb, dpc;
    logic        [9:0]  pa, pb, pc;
    dpa = $signed({3'b000, b}) - $signed({3'b000, c});
    dpb = $signed({3'b000, a}) - $signed({3'b000, c});
    dpc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa  = dpa[10] ? 10'(-dpa) : dpa[9:0];
    pb  = dpb[10] ? 10'(-dpb) : dpb[9:0];
    pc  = dpc[10] ? 10'(-dpc) : dpc[9:0];
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  // previous scanline store
  logic [7:0]       line_mem [MAX_LINE_BYTES];

  // stage 1: request plus up byte
  logic               s1_valid_q;
  psu_pkg::item_ctl_t s1_ctl_q;
  logic [7:0]         s1_x_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [7:0]         up_rd_q;

  // left and up-left history, newest first
  logic [7:0] left_q [MAX_PIXEL_BYTES];
  logic [7:0] upl_q  [MAX_PIXEL_BYTES];

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_end_q;
  logic       out_err_q;

  logic             advance;
  logic [PIX_W-1:0] hist_idx;
  logic [7:0]       a, b, c;
  logic [8:0]       ab_sum;
  logic [7:0]       pred;
  logic             err;
  logic [7:0]       recon;

  assign advance = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign pop_o   = q_valid_i && (!s1_valid_q || advance);

  // neighbors and reconstruction
  always_comb begin
    hist_idx = PIX_W'(bpp_i - psu_pkg::BPP_W'(1));
    b        = s1_ctl_q.top ? 8'd0 : up_rd_q;
    a        = s1_ctl_q.has_left ? left_q[hist_idx] : 8'd0;
    c        = (s1_ctl_q.has_left && !s1_ctl_q.top) ? upl_q[hist_idx] : 8'd0;
    ab_sum   = {1'b0, a} + {1'b0, b};
    err      = 1'b0;
    case (s1_ctl_q.kind)
      psu_pkg::FLT_NONE:  pred = 8'd0;
      psu_pkg::FLT_SUB:   pred = a;
      psu_pkg::FLT_UP:    pred = b;
      psu_pkg::FLT_AVG:   pred = ab_sum[8:1];
      psu_pkg::FLT_PAETH: pred = paeth(a, b, c);
      default: begin
        pred = 8'd0;
        err  = 1'b1;
      end
    endcase
    recon = s1_x_q + pred;
  end

  // control and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= 8'd0;
        upl_q[i]  <= 8'd0;
      end
    end else begin
      s1_valid_q  <= pop_o || (s1_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !out_ch.ready);
      if (advance) begin
        for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
          left_q[i] <= left_q[i-1];
          upl_q[i]  <= upl_q[i-1];
        end
        left_q[0] <= recon;
        upl_q[0]  <= b;
      end
    end
  end

  // line store write and read, with bypass of a same-cycle write
  always_ff @(posedge clk_i) begin
    if (advance) begin
      line_mem[s1_col_q] <= recon;
    end
    if (pop_o) begin
      up_rd_q <= (advance && s1_col_q == q_col_i) ? recon : line_mem[q_col_i];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_ctl_q <= q_ctl_i;
      s1_x_q   <= q_x_i;
      s1_col_q <= q_col_i;
    end
    if (advance) begin
      out_byte_q <= recon;
      out_end_q  <= s1_ctl_q.last;
      out_err_q  <= err;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.recon_byte   = out_byte_q;
  assign out_ch.line_end     = out_end_q;
  assign out_ch.filter_error = out_err_q;

endmodule

// ===== design/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter: config registers, front, queue, back.
//
// Usage: bytes of the decompressed stream arrive on in_ch (valid/ready), one
// request per byte. The first byte of each scanline is the filter type and
// gives no result; each data byte gives one result on out_ch carrying the
// reconstructed byte, a line-end flag and a bad-filter flag. image_start on
// a byte restarts at the top row and takes that byte as the filter type.
// Registers bytes_per_pixel (index 0) and line_bytes (index 1) are written
// through cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while the block is
// idle; the block does not enforce this. Throughput: one byte per cycle, in
// and out, unless the receiver stalls. A data byte accepted on in_ch passes
// the queue, the back-end stage register and the output register. The rate
// is set by the left-neighbor feedback and the line-store read a stage ahead.
// When the receiver stalls, the output register holds, the back end and the
// two-entry queue fill, and in_ch.ready drops once the queue is full.
// Reset clears position state to "awaiting filter byte, top row" and both
// registers to 1; the previous-line store is not cleared.
`timescale 1ns / 1ps
`include "png_scanline_unfilter_macros.svh"
module png_scanline_unfilter #(
  parameter int unsigned MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES_DEF,
  parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  psu_in_if.sink                         in_ch,
  psu_out_if.source                      out_ch
);

  localparam int unsigned COL_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int unsigned LEN_W = COL_W + 1;
  localparam int unsigned CTL_W = $bits(psu_pkg::item_ctl_t);
  localparam int unsigned Q_W   = CTL_W + psu_pkg::DATA_W + COL_W;

  logic [psu_pkg::BPP_W-1:0]        bpp_q;
  logic [psu_pkg::LINE_BYTES_W-1:0] len_q;
  logic [psu_pkg::BPP_W-1:0]        bpp_eff;
  logic [LEN_W-1:0]                 len_eff;

  logic                       q_push, q_pop;
  psu_pkg::fifo_stat_t        q_stat;
  logic [Q_W-1:0]             q_wdata, q_rdata;
  psu_pkg::item_ctl_t         f_ctl, b_ctl;
  logic [psu_pkg::DATA_W-1:0] f_x, b_x;
  logic [COL_W-1:0]           f_col, b_col;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= psu_pkg::BPP_W'(1);
      len_q <= psu_pkg::LINE_BYTES_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == psu_pkg::CFG_BYTES_PER_PIXEL) begin
        bpp_q <= cfg_data_i[psu_pkg::BPP_W-1:0];
      end else begin
        len_q <= cfg_data_i[psu_pkg::LINE_BYTES_W-1:0];
      end
    end
  end

  // clamp register values into the supported range
  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (32'(bpp_q) > 32'(MAX_PIXEL_BYTES)) begin
      bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_q;
    end
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(len_q) > 32'(MAX_LINE_BYTES)) begin
      len_eff = LEN_W'(MAX_LINE_BYTES);
    end else begin
      len_eff = LEN_W'(len_q);
    end
  end

  psu_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .bpp_i     (bpp_eff),
    .len_i     (len_eff),
    .q_ready_i (!q_stat.full),
    .push_o    (q_push),
    .ctl_o     (f_ctl),
    .x_o       (f_x),
    .col_o     (f_col)
  );

  assign q_wdata = {f_ctl, f_x, f_col};

  psu_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  assign {b_ctl, b_x, b_col} = q_rdata;

  psu_back #(
    .MAX_LINE_BYTES  (MAX_LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bpp_i     (bpp_eff),
    .q_valid_i (!q_stat.empty),
    .q_ctl_i   (b_ctl),
    .q_x_i     (b_x),
    .q_col_i   (b_col),
    .pop_o     (q_pop),
    .out_ch    (out_ch)
  );

  // queue never overflows or underflows
  `PSU_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, q_stat.full, !q_push)
  `PSU_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, q_stat.empty, !q_pop)
  // a filled queue with a stalled back end keeps the front stalled next cycle
  `PSU_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, q_stat.full && !q_pop, q_stat.full)

endmodule
